[rtl/core/cbte_pkg.sv]
package cbte_pkg;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int DW = FB + 2;
  localparam int TW = FB + 1;
  localparam int WB = 30;
  localparam int SW = 2 * CW + 4;   // sum of squares
  localparam int RW = CW + 2;       // square root width
  localparam int AW = CW + WB + 6;  // accumulator width
  localparam int MW = 36;           // serial multiplier operand width
  localparam int PW = 2 * MW;

  typedef enum logic [2:0] {
    FN_LOAD_A = 3'd0,
    FN_LOAD_B = 3'd1,
    FN_POINT  = 3'd2,
    FN_DERIV1 = 3'd3,
    FN_DERIV2 = 3'd4
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHORD,
    ST_SQRT,
    ST_CTRL,
    ST_WGT,
    ST_ACC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic          start;
    logic [MW-1:0] a;
    logic [MW-1:0] b;
    logic          neg;
  } mul_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [PW-1:0] p;
  } mul_rsp_t;

  function automatic logic signed [CW-1:0] sat_cw(input logic signed [AW-1:0] v,
                                                  output logic clip);
    logic signed [AW-1:0] hi;
    logic signed [AW-1:0] lo;
    hi = AW'((64'sd1 <<< (CW - 1)) - 1);
    lo = -hi - AW'(1);
    clip = 1'b0;
    if (v > hi) begin
      clip = 1'b1;
      sat_cw = hi[CW-1:0];
    end else if (v < lo) begin
      clip = 1'b1;
      sat_cw = lo[CW-1:0];
    end else begin
      sat_cw = v[CW-1:0];
    end
  endfunction

endpackage

[rtl/core/cubic_bezier_tangent_eval_top.sv]
// A load runs three squarings, a 34-step root and six products;
// a point or a first derivative first forms its weights, a second derivative goes straight to accumulation.
// Every general product runs on the one shift-and-add multiplier; the scalings by 3 and 6 are done in logic.
// One request at a time: the next is taken once the block is back in idle after the last finishes;
// a result still waiting in the output register holds the block at its output step.
// Synchronous active-low reset clears control state and all stored points.
module cubic_bezier_tangent_eval_top
  import cbte_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_func,
  input  logic signed [CW-1:0] in_loc_x,
  input  logic signed [CW-1:0] in_loc_y,
  input  logic signed [CW-1:0] in_loc_z,
  input  logic signed [DW-1:0] in_dir_x,
  input  logic signed [DW-1:0] in_dir_y,
  input  logic signed [DW-1:0] in_dir_z,
  input  logic [TW-1:0]        in_param,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [CW-1:0] out_vec_x,
  output logic signed [CW-1:0] out_vec_y,
  output logic signed [CW-1:0] out_vec_z,
  output logic [1:0]           out_kind,
  output logic                 out_clipped
);

  state_t state_r, state_nxt;

  logic signed [CW-1:0] pt_r [4][3];
  logic signed [CW-1:0] pt_nxt [4][3];
  logic signed [DW-1:0] da_r [3], da_nxt [3], db_r [3], db_nxt [3];
  logic [2:0]           func_r, func_nxt;
  logic [TW-1:0]        t_r, t_nxt;
  logic [4:0]           step_r, step_nxt;
  logic [1:0]           ax_r, ax_nxt;
  logic [SW-1:0]        ssum_r, ssum_nxt;
  logic signed [CW:0]   half_r, half_nxt;
  logic signed [AW-1:0] wt_r [4], wt_nxt [4];
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [CW-1:0] res_r [3], res_nxt [3];
  logic                 clip_r, clip_nxt, ov_r, ov_nxt, mreq_r, mreq_nxt;
  logic [1:0]           kind_r, kind_nxt;
  logic [MW-1:0]        ma_r, ma_nxt, mb_r, mb_nxt;
  logic                 mn_r, mn_nxt, sq_go;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  logic     sq_done;
  logic [RW-1:0] sq_root;

  assign mreq.start = mreq_r;
  assign mreq.a = ma_r;
  assign mreq.b = mb_r;
  assign mreq.neg = mn_r;

  cbte_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
  // root starts on the edge that adds the last squared difference
  cbte_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sq_go), .radicand(ssum_nxt),
                    .done(sq_done), .root(sq_root));

  function automatic logic [MW-1:0] mag(input logic signed [AW-1:0] v);
    mag = v[AW-1] ? MW'(-v) : MW'(v);
  endfunction

  function automatic logic signed [AW-1:0] rnd(input logic signed [AW-1:0] v,
                                               input int n);
    rnd = (v + (AW'(1) <<< (n - 1))) >>> n;
  endfunction

  // operand for the current accumulation step
  logic signed [AW-1:0] opnd, wsel;
  logic [1:0] ks;
  always_comb begin
    ks = step_r[1:0];
    wsel = wt_r[ks];
    opnd = '0;
    case (func_r)
      FN_POINT: opnd = AW'(pt_r[ks][ax_r]);
      FN_DERIV1: opnd = AW'(pt_r[ks+2'd1][ax_r]) - AW'(pt_r[ks][ax_r]);
      default: begin
        if (ks == 2'd0)
          opnd = AW'(pt_r[2][ax_r]) - (AW'(pt_r[1][ax_r]) <<< 1) + AW'(pt_r[0][ax_r]);
        else
          opnd = AW'(pt_r[3][ax_r]) - (AW'(pt_r[2][ax_r]) <<< 1) + AW'(pt_r[1][ax_r]);
      end
    endcase
  end

  logic [1:0] nterm;
  always_comb begin
    case (func_r)
      FN_POINT: nterm = 2'd3;
      FN_DERIV1: nterm = 2'd2;
      default: nterm = 2'd1;
    endcase
  end

  logic signed [AW-1:0] u_w, t_w, fin, dlt;
  logic signed [CW-1:0] satv;
  logic                 satc;
  always_comb begin
    t_w = AW'(t_r);
    u_w = AW'(TW'(1) << FB) - t_w;
    case (func_r)
      FN_POINT: fin = rnd(acc_r, WB);
      FN_DERIV1: fin = rnd(acc_r, WB) * AW'(3);
      default: fin = rnd(acc_r, FB) * AW'(6);
    endcase
    satv = sat_cw(fin, satc);
    dlt = AW'(pt_r[3][ax_r]) - AW'(pt_r[0][ax_r]);
  end

  logic prod_neg;
  logic ctrl_clip;
  always_comb begin
    state_nxt = state_r;
    pt_nxt = pt_r;
    da_nxt = da_r;
    db_nxt = db_r;
    func_nxt = func_r;
    t_nxt = t_r;
    step_nxt = step_r;
    ax_nxt = ax_r;
    ssum_nxt = ssum_r;
    half_nxt = half_r;
    wt_nxt = wt_r;
    acc_nxt = acc_r;
    res_nxt = res_r;
    clip_nxt = clip_r;
    ov_nxt = ov_r;
    kind_nxt = kind_r;
    mreq_nxt = 1'b0;
    ma_nxt = ma_r;
    mb_nxt = mb_r;
    mn_nxt = mn_r;
    sq_go = 1'b0;
    prod_neg = 1'b0;
    ctrl_clip = 1'b0;
    in_stall = 1'b1;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          func_nxt = in_func;
          t_nxt = (in_param > (TW'(1) << FB)) ? (TW'(1) << FB) : in_param;
          ax_nxt = '0;
          step_nxt = '0;
          if (in_func == FN_LOAD_A || in_func == FN_LOAD_B) begin
            if (in_func == FN_LOAD_A) begin
              pt_nxt[0][0] = in_loc_x; pt_nxt[0][1] = in_loc_y; pt_nxt[0][2] = in_loc_z;
              da_nxt[0] = in_dir_x; da_nxt[1] = in_dir_y; da_nxt[2] = in_dir_z;
            end else begin
              pt_nxt[3][0] = in_loc_x; pt_nxt[3][1] = in_loc_y; pt_nxt[3][2] = in_loc_z;
              db_nxt[0] = in_dir_x; db_nxt[1] = in_dir_y; db_nxt[2] = in_dir_z;
            end
            ssum_nxt = '0;
            state_nxt = ST_CHORD;
          end else if (in_func == FN_POINT || in_func == FN_DERIV1
                       || in_func == FN_DERIV2) begin
            acc_nxt = '0;
            clip_nxt = 1'b0;
            state_nxt = (in_func == FN_DERIV2) ? ST_ACC : ST_WGT;
            if (in_func == FN_DERIV2) begin
              wt_nxt[0] = AW'(TW'(1) << FB) - AW'(t_nxt);
              wt_nxt[1] = AW'(t_nxt);
            end
          end
        end
      end
      ST_CHORD: begin
        // one squared difference per multiplier pass
        if (step_r[0] == 1'b0) begin
          ma_nxt = mag(dlt);
          mb_nxt = mag(dlt);
          mn_nxt = 1'b0;
          mreq_nxt = 1'b1;
          step_nxt = 5'd1;
        end else if (mrsp.done) begin
          ssum_nxt = ssum_r + SW'(mrsp.p);
          step_nxt = '0;
          if (ax_r == 2'd2) begin
            ax_nxt = '0;
            sq_go = 1'b1;
            state_nxt = ST_SQRT;
          end else ax_nxt = ax_r + 2'd1;
        end
      end
      ST_SQRT: begin
        if (sq_done) begin
          half_nxt = $signed({1'b0, sq_root[CW:1]});
          step_nxt = '0;
          state_nxt = ST_CTRL;
        end
      end
      ST_CTRL: begin
        // step[1] picks C1 or C2, step[0] issue/collect
        if (step_r[0] == 1'b0) begin
          prod_neg = step_r[1] ? db_r[ax_r][DW-1] : da_r[ax_r][DW-1];
          ma_nxt = step_r[1] ? mag(AW'(db_r[ax_r])) : mag(AW'(da_r[ax_r]));
          mb_nxt = MW'(half_r);
          mn_nxt = prod_neg;
          mreq_nxt = 1'b1;
          step_nxt = step_r | 5'd1;
        end else if (mrsp.done) begin
          if (step_r[1])
            pt_nxt[2][ax_r] = sat_cw(AW'(pt_r[3][ax_r])
                               - rnd(AW'(mrsp.p), FB), ctrl_clip);
          else
            pt_nxt[1][ax_r] = sat_cw(AW'(pt_r[0][ax_r])
                               + rnd(AW'(mrsp.p), FB), ctrl_clip);
          if (step_r[1]) begin
            step_nxt = '0;
            if (ax_r == 2'd2) begin
              ax_nxt = '0;
              state_nxt = ST_IDLE;
            end else ax_nxt = ax_r + 2'd1;
          end else step_nxt = 5'd2;
        end
      end
      ST_WGT: begin
        // step 0: u*u, 1: u*t, 2: t*t, 3..: cubic terms, for a point only
        if (step_r[0] == 1'b0) begin
          mn_nxt = 1'b0;
          mreq_nxt = 1'b1;
          case (step_r[4:1])
            4'd0: begin ma_nxt = MW'(u_w); mb_nxt = MW'(u_w); end
            4'd1: begin ma_nxt = MW'(u_w); mb_nxt = MW'(t_w); end
            4'd2: begin ma_nxt = MW'(t_w); mb_nxt = MW'(t_w); end
            4'd3: begin ma_nxt = MW'(wt_r[0]); mb_nxt = MW'(u_w); end
            4'd4: begin ma_nxt = MW'(wt_r[1]); mb_nxt = MW'(u_w); end
            4'd5: begin ma_nxt = MW'(wt_r[2]); mb_nxt = MW'(u_w); end
            default: begin ma_nxt = MW'(wt_r[2]); mb_nxt = MW'(t_w); end
          endcase
          step_nxt = step_r | 5'd1;
        end else if (mrsp.done) begin
          case (step_r[4:1])
            4'd0: wt_nxt[0] = AW'(mrsp.p);
            4'd1: wt_nxt[1] = AW'(mrsp.p);
            4'd2: wt_nxt[2] = AW'(mrsp.p);
            4'd3: wt_nxt[0] = rnd(AW'(mrsp.p), 3 * FB - WB);
            4'd4: wt_nxt[3] = AW'(mrsp.p);
            4'd5: begin
              wt_nxt[3] = rnd(AW'(3) * wt_r[3], 3 * FB - WB);
              wt_nxt[1] = AW'(mrsp.p);
            end
            default: begin
              wt_nxt[2] = rnd(AW'(3) * wt_r[1], 3 * FB - WB);
              wt_nxt[3] = rnd(AW'(mrsp.p), 3 * FB - WB);
              wt_nxt[1] = wt_r[3];
            end
          endcase
          step_nxt = {step_r[4:1] + 4'd1, 1'b0};
          if (func_r == FN_DERIV1 && step_r[4:1] == 4'd2) begin
            wt_nxt[0] = rnd(wt_r[0], 2 * FB - WB);
            wt_nxt[1] = rnd(wt_r[1] <<< 1, 2 * FB - WB);
            wt_nxt[2] = rnd(AW'(mrsp.p), 2 * FB - WB);
            step_nxt = '0;
            state_nxt = ST_ACC;
          end else if (step_r[4:1] == 4'd6) begin
            // reorder: w0 u^3, w1 3u^2t, w2 3ut^2, w3 t^3
            step_nxt = '0;
            state_nxt = ST_ACC;
          end
        end
      end
      ST_ACC: begin
        if (step_r[4] == 1'b0) begin
          ma_nxt = mag(wsel);
          mb_nxt = mag(opnd);
          mn_nxt = wsel[AW-1] ^ opnd[AW-1];
          mreq_nxt = 1'b1;
          step_nxt = step_r | 5'h10;
        end else if (mrsp.done) begin
          acc_nxt = acc_r + AW'(mrsp.p);
          if (step_r[1:0] == nterm) begin
            step_nxt = '0;
            state_nxt = ST_OUT;
          end else step_nxt = {3'b000, step_r[1:0] + 2'd1};
        end
      end
      ST_OUT: begin
        if (!ov_r || !out_stall) begin
          res_nxt[ax_r] = satv;
          clip_nxt = clip_r | satc;
          acc_nxt = '0;
          step_nxt = '0;
          if (ax_r == 2'd2) begin
            ax_nxt = '0;
            ov_nxt = 1'b1;
            kind_nxt = 2'(func_r - 3'(FN_POINT));
            state_nxt = ST_IDLE;
          end else begin
            ax_nxt = ax_r + 2'd1;
            state_nxt = ST_ACC;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // finished vector held separately from working registers
  logic signed [CW-1:0] ox_r, oy_r, oz_r;
  logic                 oc_r;
  logic [1:0]           ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r <= 1'b0;
      mreq_r <= 1'b0;
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 3; j++) pt_r[i][j] <= '0;
      for (int j = 0; j < 3; j++) begin
        da_r[j] <= '0;
        db_r[j] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      mreq_r <= mreq_nxt;
      pt_r <= pt_nxt;
      da_r <= da_nxt;
      db_r <= db_nxt;
    end
    func_r <= func_nxt;
    t_r <= t_nxt;
    step_r <= (!rst_n) ? '0 : step_nxt;
    ax_r <= (!rst_n) ? '0 : ax_nxt;
    ssum_r <= ssum_nxt;
    half_r <= half_nxt;
    wt_r <= wt_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
    clip_r <= clip_nxt;
    kind_r <= kind_nxt;
    ma_r <= ma_nxt;
    mb_r <= mb_nxt;
    mn_r <= mn_nxt;
    if (state_r == ST_OUT && ax_r == 2'd2 && (!ov_r || !out_stall)) begin
      ox_r <= res_r[0];
      oy_r <= res_r[1];
      oz_r <= satv;
      oc_r <= clip_r | satc;
      ok_r <= kind_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_vec_x = ox_r;
  assign out_vec_y = oy_r;
  assign out_vec_z = oz_r;
  assign out_kind = ok_r;
  assign out_clipped = oc_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_vec_x))
    else $error("result changed while stalled");
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> state_r == ST_IDLE)
    else $error("request taken while busy");
  a_kind_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind != 2'd3)
    else $error("bad result kind");

endmodule

[rtl/core/cbte_mul.sv]
// Radix-2 shift-and-add multiplier: one operand bit per cycle.
module cbte_mul
  import cbte_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic [MW-1:0] b_r, b_nxt;
  logic [PW-1:0] acc_r, acc_nxt, a_r, a_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, neg_r, neg_nxt, done_r, done_nxt;

  always_comb begin
    b_nxt = b_r;
    a_nxt = a_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    neg_nxt = neg_r;
    done_nxt = 1'b0;
    if (req.start) begin
      a_nxt = PW'(req.a);
      b_nxt = req.b;
      acc_nxt = '0;
      cnt_nxt = 7'(MW);
      busy_nxt = 1'b1;
      neg_nxt = req.neg;
    end else if (busy_r) begin
      if (b_r[0]) acc_nxt = acc_r + a_r;
      a_nxt = a_r << 1;
      b_nxt = b_r >> 1;
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.p = neg_r ? -$signed(acc_r) : $signed(acc_r);

endmodule

[rtl/core/cbte_sqrt.sv]
// Restoring square root, one result bit per cycle.
module cbte_sqrt
  import cbte_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [SW-1:0] radicand,
  output logic          done,
  output logic [RW-1:0] root
);

  logic [SW-1:0] rem_r, rem_nxt, q_r, q_nxt, bit_r, bit_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    rem_nxt = rem_r;
    q_nxt = q_r;
    bit_nxt = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = radicand;
      q_nxt = '0;
      bit_nxt = SW'(1) << (2 * (RW - 1));
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= (q_r | bit_r)) begin
        rem_nxt = rem_r - (q_r | bit_r);
        q_nxt = (q_r >> 1) | bit_r;
      end else begin
        q_nxt = q_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = q_r[RW-1:0];

endmodule
